// ===== src/bsra_pkg.sv =====
// Shared types, codes and helper functions of the bitmap slot range allocator.
// Depends on nothing; the allocator top level and its testbench import it.
package bsra_pkg;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } bsra_state_t;

  // Command codes of the input beat.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes of the result beat.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_ROOM  = 2'd1;
  localparam logic [1:0] STAT_BAD_FREE = 2'd2;

  // Smallest table is 16 slots, which is also the width of one bitmap row.
  localparam int unsigned MIN_LOG2 = 4;

  // Index of the lowest set bit of a row, or 16 when no bit is set.
  function automatic logic [4:0] lowest_set(input logic [15:0] v);
    logic [4:0] r;
    r = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  // Number of consecutive set bits starting at bit 0 (0 to 16).
  function automatic logic [4:0] trailing_ones(input logic [15:0] v);
    logic [4:0] r;
    r = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (!v[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

// ===== src/bsra_in_if.sv =====
// Command channel of the bitmap slot range allocator: valid/ready plus payload.
// Depends on nothing; widths follow the LM parameter (log2 of the slot count).
interface bsra_in_if #(parameter int LM = 10) ();
  logic          valid;
  logic          ready;
  logic          cmd;
  logic [LM:0]   count;
  logic [LM-1:0] slot;

  modport source (output valid, cmd, count, slot, input ready);
  modport sink   (input valid, cmd, count, slot, output ready);
endinterface

// ===== src/bsra_out_if.sv =====
// Result channel of the bitmap slot range allocator: valid/ready plus payload.
// Depends on nothing; widths follow the LM parameter (log2 of the slot count).
interface bsra_out_if #(parameter int LM = 10) ();
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [LM-1:0] start_slot;
  logic [LM:0]   slots_used;

  modport source (output valid, status, start_slot, slots_used, input ready);
  modport sink   (input valid, status, start_slot, slots_used, output ready);
endinterface

// ===== src/bitmap_slot_range_allocator.sv =====
// Top level of the bitmap slot range allocator: controller and bitmap memory.
// Depends on bsra_pkg, bsra_in_if and bsra_out_if.
//
// Usage: each beat on in_ch is one command. Allocate (cmd 0) looks next-fit
// from the search hint, once around the table, for count consecutive free
// slots, marks them used and returns the first one. Free (cmd 1) clears one
// used slot. Every command gives exactly one beat on out_ch with the status,
// the first slot of the run and the number of used slots afterwards.
// cfg_wr_en/cfg_wr_data write log2_size (table size, clamped to 4..max).
// The used bits sit in a memory of 16-slot rows with a registered read port.
// A free reads the row of its slot, then writes it back. An allocate
// alternates reading one row and scanning it, scans a row again for each
// run broken inside it, then reads and writes back each row it marks;
// rejected commands go straight to the result step. The search loop (read
// one row, then scan it) sets the allocate time.
// Commands are handled one at a time; in_ch.ready is high while idle, also
// while a result waits in the output register for out_ch.ready. A stalled
// receiver holds the next result back until the output register frees up.
// After reset the memory is cleared row by row, all 2^(LOG2_MAX_SLOTS-4)
// rows (64 at the default), before the first command is taken; slot 0 is left
// used and can never be freed.
module bitmap_slot_range_allocator import bsra_pkg::*; #(
  parameter int LOG2_MAX_SLOTS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  bsra_in_if.sink     in_ch,
  bsra_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  localparam int LM   = LOG2_MAX_SLOTS;
  localparam int SW   = LM + 1;                  // sizes, counts, totals
  localparam int PW   = LM + 2;                  // unwrapped search positions
  localparam int ROWS = 1 << (LM - MIN_LOG2);
  localparam int RAW  = (LM > MIN_LOG2) ? LM - MIN_LOG2 : 1;

  // Bitmap memory.
  logic [15:0]    mem [ROWS];
  logic           mem_we;
  logic [RAW-1:0] mem_waddr;
  logic [15:0]    mem_wdata;
  logic           mem_re;
  logic [RAW-1:0] mem_raddr;
  logic [15:0]    rd_data_r;

  // Control and state registers.
  bsra_state_t    state_r, state_nxt;
  logic [3:0]     log2_size_r, log2_size_nxt;
  logic [LM-1:0]  hint_r, hint_nxt;
  logic [SW-1:0]  total_r, total_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;
  logic [LM-1:0]  slot_r, slot_nxt;
  logic [PW-1:0]  base_r, base_nxt;
  logic [3:0]     off_r, off_nxt;
  logic [SW-1:0]  run_r, run_nxt;
  logic [PW-1:0]  start_r, start_nxt;
  logic [PW-1:0]  end_r, end_nxt;
  logic [PW-1:0]  lim_r, lim_nxt;
  logic [PW-1:0]  mark_base_r, mark_base_nxt;
  logic [RAW-1:0] clr_addr_r, clr_addr_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic [LM-1:0]  res_start_r, res_start_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [LM-1:0]  out_start_r, out_start_nxt;
  logic [SW-1:0]  out_used_r, out_used_nxt;

  // Table geometry from the clamped size register.
  logic [4:0]     eff_log2;
  logic [SW-1:0]  size_w;
  logic [LM-1:0]  slot_mask;
  logic [RAW-1:0] row_mask;

  always_comb begin
    if (log2_size_r < 4'(MIN_LOG2)) begin
      eff_log2 = 5'(MIN_LOG2);
    end else if ({1'b0, log2_size_r} > 5'(LM)) begin
      eff_log2 = 5'(LM);
    end else begin
      eff_log2 = {1'b0, log2_size_r};
    end
  end

  assign size_w    = SW'(1) << eff_log2;
  assign slot_mask = LM'(size_w - SW'(1));
  assign row_mask  = RAW'((size_w >> MIN_LOG2) - SW'(1));

  // Row scan: find the next free slot in the current row and the length of
  // the free run that starts there. An open run always continues at bit 0.
  logic [15:0]   free_w;
  logic [15:0]   seek_m;
  logic [4:0]    lo_idx;
  logic [3:0]    f_idx;
  logic          no_free;
  logic [4:0]    run_len;
  logic [PW-1:0] pf;
  logic [SW-1:0] tot;
  logic          fits;
  logic          hits_end;
  logic [PW-1:0] base_step;
  logic [PW-1:0] new_start;
  logic [PW-1:0] new_end;

  assign free_w    = ~rd_data_r;
  assign seek_m    = free_w & (16'hFFFF << off_r);
  assign lo_idx    = lowest_set(seek_m);
  assign f_idx     = (run_r != '0) ? 4'd0 : lo_idx[3:0];
  assign no_free   = (run_r == '0) && lo_idx[4];
  assign run_len   = trailing_ones(free_w >> f_idx);
  assign pf        = base_r + PW'(f_idx);
  assign tot       = run_r + SW'(run_len);
  assign fits      = tot >= cnt_r;
  assign hits_end  = ({1'b0, f_idx} + run_len) == 5'd16;
  assign base_step = base_r + PW'(16);
  assign new_start = (run_r != '0) ? start_r : pf;
  assign new_end   = pf + PW'(cnt_r - run_r) - PW'(1);

  // Bits of the current marking row that belong to the run.
  logic [3:0]  mark_lo;
  logic [3:0]  mark_hi;
  logic [15:0] mark_bits;
  logic        mark_last;

  assign mark_last = mark_base_r[PW-1:4] == end_r[PW-1:4];
  assign mark_lo   = (mark_base_r[PW-1:4] == start_r[PW-1:4]) ? start_r[3:0] : 4'd0;
  assign mark_hi   = mark_last ? end_r[3:0] : 4'd15;
  assign mark_bits = (16'hFFFF << mark_lo) & (16'hFFFF >> (4'd15 - mark_hi));

  // Hint as a position inside the current table.
  logic [LM-1:0] idx0;
  assign idx0 = hint_r & slot_mask;

  // Handshakes.
  assign in_ch.ready       = state_r == ST_IDLE;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.start_slot = out_start_r;
  assign out_ch.slots_used = out_used_r;

  // Next state and memory port control.
  always_comb begin
    state_nxt      = state_r;
    log2_size_nxt  = cfg_wr_en ? cfg_wr_data : log2_size_r;
    hint_nxt       = hint_r;
    total_nxt      = total_r;
    cnt_nxt        = cnt_r;
    slot_nxt       = slot_r;
    base_nxt       = base_r;
    off_nxt        = off_r;
    run_nxt        = run_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    lim_nxt        = lim_r;
    mark_base_nxt  = mark_base_r;
    clr_addr_nxt   = clr_addr_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_used_nxt   = out_used_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state_r)
      ST_CLEAR: begin
        // Sweep the memory once; row 0 keeps slot 0 reserved.
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = (clr_addr_r == '0) ? 16'h0001 : 16'h0000;
        clr_addr_nxt = clr_addr_r + RAW'(1);
        if (clr_addr_r == RAW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          res_start_nxt = '0;
          cnt_nxt       = in_ch.count;
          slot_nxt      = in_ch.slot;
          if (in_ch.cmd == CMD_ALLOC) begin
            if (in_ch.count == '0 || in_ch.count > size_w || total_r >= size_w) begin
              res_status_nxt = STAT_NO_ROOM;
              state_nxt      = ST_DONE;
            end else begin
              base_nxt  = PW'(idx0 & ~LM'(15));
              off_nxt   = idx0[3:0];
              lim_nxt   = PW'(size_w) + PW'(idx0);
              run_nxt   = '0;
              state_nxt = ST_SRCH_RD;
            end
          end else begin
            if (in_ch.slot == '0 || {1'b0, in_ch.slot} >= size_w) begin
              res_status_nxt = STAT_BAD_FREE;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt = ST_FREE_RD;
            end
          end
        end
      end

      ST_SRCH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = RAW'(base_r >> 4) & row_mask;
        state_nxt = ST_SRCH;
      end

      ST_SRCH: begin
        if (no_free) begin
          // Nothing free in the rest of this row: next row or give up.
          if (base_step >= lim_r) begin
            res_status_nxt = STAT_NO_ROOM;
            state_nxt      = ST_DONE;
          end else begin
            base_nxt  = base_step;
            off_nxt   = 4'd0;
            state_nxt = ST_SRCH_RD;
          end
        end else if (run_r == '0 && pf >= lim_r) begin
          // A new run may not start beyond one turn of the table.
          res_status_nxt = STAT_NO_ROOM;
          state_nxt      = ST_DONE;
        end else if (fits) begin
          start_nxt     = new_start;
          end_nxt       = new_end;
          mark_base_nxt = {new_start[PW-1:4], 4'b0000};
          state_nxt     = ST_MARK_RD;
        end else if (hits_end) begin
          // Run reaches the row end: carry it into the next row.
          run_nxt   = tot;
          start_nxt = new_start;
          base_nxt  = base_step;
          off_nxt   = 4'd0;
          state_nxt = ST_SRCH_RD;
        end else begin
          // Run broken by a used slot inside this row: rescan from there.
          run_nxt = '0;
          off_nxt = f_idx + run_len[3:0];
        end
      end

      ST_MARK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = RAW'(mark_base_r >> 4) & row_mask;
        state_nxt = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = RAW'(mark_base_r >> 4) & row_mask;
        mem_wdata = rd_data_r | mark_bits;
        if (mark_last) begin
          total_nxt      = total_r + cnt_r;
          hint_nxt       = LM'(end_r + PW'(1)) & slot_mask;
          res_status_nxt = STAT_OK;
          res_start_nxt  = LM'(start_r) & slot_mask;
          state_nxt      = ST_DONE;
        end else begin
          mark_base_nxt = mark_base_r + PW'(16);
          state_nxt     = ST_MARK_RD;
        end
      end

      ST_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = RAW'(PW'(slot_r) >> 4);
        state_nxt = ST_FREE_WR;
      end

      ST_FREE_WR: begin
        if (rd_data_r[slot_r[3:0]]) begin
          mem_we         = 1'b1;
          mem_waddr      = RAW'(PW'(slot_r) >> 4);
          mem_wdata      = rd_data_r & ~(16'h0001 << slot_r[3:0]);
          hint_nxt       = slot_r;
          total_nxt      = (total_r != '0) ? total_r - SW'(1) : total_r;
          res_status_nxt = STAT_OK;
        end else begin
          res_status_nxt = STAT_BAD_FREE;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Load the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          out_used_nxt   = total_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers with a reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_size_r <= 4'd10;
      hint_r      <= '0;
      total_r     <= SW'(1);
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      log2_size_r <= log2_size_nxt;
      hint_r      <= hint_nxt;
      total_r     <= total_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    slot_r       <= slot_nxt;
    base_r       <= base_nxt;
    off_r        <= off_nxt;
    run_r        <= run_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    lim_r        <= lim_nxt;
    mark_base_r  <= mark_base_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_used_r   <= out_used_nxt;
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

`ifndef SYNTH
  // Slot 0 stays reserved: no write after the clearing sweep drops its bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_waddr == '0 && state_r != ST_CLEAR) |-> mem_wdata[0])
    else $error("slot 0 bit cleared");

  // The search never walks past the last position a run could end on.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH || state_r == ST_SRCH_RD) |-> (base_r < lim_r + PW'(cnt_r)))
    else $error("search ran past its limit");

  // A result beat is only raised by the controller's result step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the result step");
`endif

endmodule

// ===== tb/bitmap_slot_range_allocator_tb.sv =====
// Self-checking testbench for the bitmap slot range allocator.
// Needs bsra_pkg, bsra_in_if, bsra_out_if and bitmap_slot_range_allocator.
// A next-fit allocation predictor in the bench checks every result beat.
module bitmap_slot_range_allocator_tb;
  import bsra_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int MAX_LOG2       = 10;
  localparam int MAX_SLOTS      = 1 << MAX_LOG2;
  localparam int LONG_HOLD      = 200;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int PHASE_ITEMS    = 120;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  start_slot;
    logic [10:0] slots_used;
  } slot_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;

  bsra_in_if  #(.LM(MAX_LOG2)) in_ch ();
  bsra_out_if #(.LM(MAX_LOG2)) out_ch ();

  bitmap_slot_range_allocator #(.LOG2_MAX_SLOTS(MAX_LOG2)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predicted allocator state, updated as each command beat is accepted.
  bit           slot_used [MAX_SLOTS];
  logic [9:0]   next_fit_hint;
  logic [10:0]  used_count;
  logic [3:0]   size_log2_reg;

  slot_result_t results_due[$];
  int           fail_count = 0;
  int           send_gap_pct = 0;
  int           recv_gap_pct = 0;
  bit           hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Number of slots in the table for the current register value.
  function automatic int unsigned table_slots();
    int unsigned lg;
    lg = size_log2_reg;
    if (lg < MIN_LOG2) lg = MIN_LOG2;
    if (lg > MAX_LOG2) lg = MAX_LOG2;
    return 1 << lg;
  endfunction

  // Applies one command to the predicted state and returns its result.
  function automatic slot_result_t predict_command(input logic c, input logic [10:0] n,
                                                   input logic [9:0] s);
    int unsigned  size, mask, idx, lim, first, i, len;
    bit           whole, found;
    slot_result_t r;
    size = table_slots();
    mask = size - 1;
    len = n;
    r.start_slot = '0;
    if (c == CMD_FREE) begin
      r.status = STAT_BAD_FREE;
      if (s != 0 && s < size && slot_used[s]) begin
        slot_used[s] = 1'b0;
        next_fit_hint = s;
        if (used_count > 0) used_count = used_count - 1'b1;
        r.status = STAT_OK;
      end
      r.slots_used = used_count;
      return r;
    end
    r.status = STAT_NO_ROOM;
    r.slots_used = used_count;
    if (len == 0 || len > size || used_count >= size) return r;
    // Next-fit scan, once around the table; runs through the top slot are skipped.
    idx = next_fit_hint & mask;
    lim = size + idx;
    found = 1'b0;
    while (!found) begin
      whole = 1'b1;
      while (idx < lim && slot_used[idx & mask]) idx++;
      if (idx >= lim) return r;
      for (i = 1; i < len; i++) begin
        idx++;
        if (slot_used[idx & mask]) begin
          whole = 1'b0;
          break;
        end
      end
      if (whole) begin
        first = idx - len + 1;
        found = !(first < size && idx >= size);
      end
    end
    for (i = first; i <= idx; i++) slot_used[i & mask] = 1'b1;
    used_count = 11'(used_count + len);
    next_fit_hint = 10'((idx + 1) & mask);
    r.status = STAT_OK;
    r.start_slot = 10'(first & mask);
    r.slots_used = used_count;
    return r;
  endfunction

  // Offers one command beat and records its expected result on acceptance.
  task automatic send_beat(input logic c, input logic [10:0] n, input logic [9:0] s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd   = c;
    in_ch.count = n;
    in_ch.slot  = s;
    do @(posedge clk); while (!in_ch.ready);
    results_due.push_back(predict_command(c, n, s));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic wait_all_results();
    while (results_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Changes the table size while the block is idle.
  task automatic set_table_log2(input logic [3:0] v);
    wait_all_results();
    cfg_wr_data = v;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    size_log2_reg = v;
  endtask

  // Frees every used slot inside the current table.
  task automatic free_all_slots();
    for (int s = 1; s < table_slots(); s++) begin
      if (slot_used[s]) send_beat(CMD_FREE, '0, 10'(s));
    end
  endtask

  // Zero count, oversize counts, a whole-table count, the reserved slot and a never-used slot.
  task automatic test_reject_cases();
    send_beat(CMD_ALLOC, 11'd0, 10'd0);
    send_beat(CMD_ALLOC, 11'd2047, 10'd1023);
    send_beat(CMD_ALLOC, 11'd1025, 10'd0);
    send_beat(CMD_ALLOC, 11'd1024, 10'd0);
    send_beat(CMD_FREE, 11'd0, 10'd0);
    send_beat(CMD_FREE, 11'd2047, 10'd1023);
  endtask

  // Hint movement after allocations and frees, plus a double free.
  task automatic test_next_fit();
    send_beat(CMD_ALLOC, 11'd1, '0);
    send_beat(CMD_ALLOC, 11'd20, '0);
    send_beat(CMD_FREE, '0, 10'd10);
    send_beat(CMD_ALLOC, 11'd1, '0);
    send_beat(CMD_ALLOC, 11'd2, '0);
    send_beat(CMD_FREE, '0, 10'd10);
    send_beat(CMD_FREE, '0, 10'd10);
  endtask

  // Shrinks the table with a used slot and the hint above the new size.
  task automatic test_shrunk_table();
    free_all_slots();
    send_beat(CMD_ALLOC, 11'd1, '0);
    set_table_log2(4'd0);
    send_beat(CMD_ALLOC, 11'd3, '0);
    send_beat(CMD_FREE, '0, next_fit_hint - 10'd4);
    send_beat(CMD_ALLOC, 11'd14, '0);
    set_table_log2(4'd15);
    free_all_slots();
  endtask

  // Fills the smallest table and checks the full and fragmented cases.
  task automatic test_full_table();
    set_table_log2(4'd4);
    send_beat(CMD_ALLOC, 11'd15, '0);
    send_beat(CMD_ALLOC, 11'd1, '0);
    send_beat(CMD_ALLOC, 11'd16, '0);
    send_beat(CMD_FREE, '0, 10'd7);
    send_beat(CMD_ALLOC, 11'd2, '0);
    send_beat(CMD_ALLOC, 11'd1, '0);
  endtask

  // The receiver stalls for a long stretch while commands keep coming.
  task automatic test_output_stall();
    hold_req = 1'b1;
    for (int k = 0; k < 12; k++) send_beat(CMD_ALLOC, 11'($urandom_range(1, 3)), '0);
    free_all_slots();
  endtask

  // Mostly well-formed allocate and free traffic for one table size.
  task automatic test_random_traffic(input logic [3:0] v, input int items);
    int unsigned size, cap, s0, pick;
    int          k;
    set_table_log2(v);
    size = table_slots();
    cap = (size >= 64) ? 8 : 4;
    for (k = 0; k < items; k++) begin
      if (k == items / 2) wait_all_results();
      if ($urandom_range(99) < 5) begin
        send_beat(1'($urandom_range(1)), 11'($urandom_range(2047)),
                  10'($urandom_range(1023)));
      end else if ($urandom_range(99) < ((used_count * 4 < size * 3) ? 60 : 30)) begin
        if ($urandom_range(99) < 88)
          send_beat(CMD_ALLOC, 11'($urandom_range(1, cap)), 10'($urandom_range(1023)));
        else
          send_beat(CMD_ALLOC, 11'($urandom_range(1, size)), 10'($urandom_range(1023)));
      end else begin
        // Free a used slot found from a random start, if there is one.
        s0 = $urandom_range(size - 1);
        pick = s0;
        for (int j = 0; j < size; j++) begin
          if ((s0 + j) % size != 0 && slot_used[(s0 + j) % size]) begin
            pick = (s0 + j) % size;
            break;
          end
        end
        send_beat(CMD_FREE, 11'($urandom_range(2047)), 10'(pick));
      end
    end
  endtask

  // Receiver: random ready, with a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d start_slot %0d used %0d",
                 $time, out_ch.status, out_ch.start_slot, out_ch.slots_used);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.start_slot !== want.start_slot) begin
          $display("%0t: start_slot expected %0d, got %0d", $time, want.start_slot,
                   out_ch.start_slot);
          fail_count++;
        end
        if (out_ch.slots_used !== want.slots_used) begin
          $display("%0t: slots_used expected %0d, got %0d", $time, want.slots_used,
                   out_ch.slots_used);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed cases, then random traffic per table size.
  initial begin
    logic [3:0] phase_log2 [10];
    phase_log2 = '{4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd15};
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_ALLOC;
    in_ch.count = '0;
    in_ch.slot  = '0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    slot_used[0]  = 1'b1;
    next_fit_hint = '0;
    used_count    = 11'd1;
    size_log2_reg = 4'd10;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reject_cases();
    test_next_fit();
    test_shrunk_table();
    test_full_table();
    test_output_stall();
    for (int p = 0; p < 10; p++) begin
      if (p < 3) begin
        send_gap_pct = 7;
        recv_gap_pct = 78;
      end else if (p < 6) begin
        send_gap_pct = 78;
        recv_gap_pct = 7;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      test_random_traffic(phase_log2[p], PHASE_ITEMS);
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule
